// File: design/rpn_stack_calculator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RPN calculator design files.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_CORE_DEFINES_SVH
`define RPN_STACK_CALCULATOR_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RPN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant checked on every rising clock edge outside reset.
`define RPN_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// File: design/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Types, codes and constants of the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int StackDepthDef = 16;
    localparam int MaxResults    = 16;

    typedef enum logic [3:0] {
        CMD_PUSH  = 4'd0,
        CMD_ADD   = 4'd1,
        CMD_SUB   = 4'd2,
        CMD_MUL   = 4'd3,
        CMD_DIV   = 4'd4,
        CMD_SWAP  = 4'd5,
        CMD_DUP   = 4'd6,
        CMD_TOP   = 4'd7,
        CMD_ALL   = 4'd8,
        CMD_CLEAR = 4'd9
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_DIVZERO  = 3'd4,
        ST_INVALID  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ALU_MUL = 2'd0,
        ALU_DIV = 2'd1
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_ALU_WAIT,
        S_SWAP_WR,
        S_SHOW_RD,
        S_SHOW_OUT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [3:0]  command;
        logic signed [31:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic signed [31:0] result_value;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic         start;
        t_alu_op      op;
        logic [31:0]  a;
        logic [31:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic         done;
        logic         ovf;
        logic [31:0]  value;
    } t_alu_rsp;

endpackage

// File: design/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu
// Bit-serial signed multiplier and divider, one bit per cycle, with
// overflow detection. Division truncates toward zero.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_core_defines.svh"

module rpn_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpn_pkg::t_alu_req i_req,
    output rpn_pkg::t_alu_rsp o_rsp
);

    logic                r_busy, n_busy;
    logic [5:0]          r_cnt, n_cnt;
    rpn_pkg::t_alu_op    r_op, n_op;
    logic                r_neg, n_neg;
    logic [31:0]         r_mcand, n_mcand;   // |a| for multiply, divisor for divide
    logic [63:0]         r_acc, n_acc;       // product, or {rem, quotient}
    logic                r_done, n_done;

    logic [31:0] w_abs_a, w_abs_b;
    logic [32:0] w_sum;
    logic [32:0] w_diff;
    logic [63:0] w_res;
    logic [63:0] w_res_s;

    assign w_abs_a = i_req.a[31] ? (~i_req.a + 32'd1) : i_req.a;
    assign w_abs_b = i_req.b[31] ? (~i_req.b + 32'd1) : i_req.b;
    assign w_sum   = {1'b0, r_acc[63:32]} + (r_acc[0] ? {1'b0, r_mcand} : 33'd0);
    assign w_diff  = {r_acc[63:31]} - {1'b0, r_mcand};

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_neg   = r_neg;
        n_mcand = r_mcand;
        n_acc   = r_acc;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_cnt   = 6'd0;
            n_op    = i_req.op;
            n_neg   = i_req.a[31] ^ i_req.b[31];
            if (i_req.op == rpn_pkg::ALU_MUL) begin
                n_mcand = w_abs_a;
                n_acc   = {32'd0, w_abs_b};
            end else begin
                n_mcand = w_abs_b;
                n_acc   = {32'd0, w_abs_a};
            end
        end else if (r_busy) begin
            if (r_op == rpn_pkg::ALU_MUL) begin
                // shift-add: add multiplicand on the low bit, shift right
                n_acc = {w_sum, r_acc[31:1]};
            end else if (!w_diff[32]) begin
                // restoring division: subtract when it fits
                n_acc = {w_diff[31:0], r_acc[30:0], 1'b1};
            end else begin
                n_acc = {r_acc[62:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op    <= n_op;
        r_neg   <= n_neg;
        r_mcand <= n_mcand;
        r_acc   <= n_acc;
    end

    // Apply the sign and check the range of the magnitude.
    always_comb begin
        if (r_op == rpn_pkg::ALU_MUL) begin
            w_res = r_acc;
        end else begin
            w_res = {32'd0, r_acc[31:0]};
        end
        w_res_s = r_neg ? (~w_res + 64'd1) : w_res;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = w_res_s[31:0];
    assign o_rsp.ovf   = r_neg ? (w_res > 64'h8000_0000) : (w_res > 64'h7FFF_FFFF);

    `RPN_ASSERT_IMPL(a_done_single, i_clk, i_rst_n, r_done, !r_busy, "alu done while busy")
    `RPN_ASSERT_IMPL(a_no_restart, i_clk, i_rst_n, r_busy, !i_req.start, "alu restarted while busy")
    `RPN_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, r_busy, r_cnt <= 6'd31, "alu count out of range")

endmodule

// File: design/rpn_stack_calculator_core.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core
// Reverse Polish calculator on 32-bit signed integers with checked results.
// ----------------------------------------------------------------------------
// One command is taken at a time; o_in_stall is held high until its last
// result transfers. Mul and div use the shared serial unit, which works one
// bit per cycle and then hands its result over; show all reports each entry
// in turn (address, registered read, result). Stack entries live in a
// register memory with one write port and one registered read port.
`include "rpn_stack_calculator_core_defines.svh"

module rpn_stack_calculator_core #(
    parameter int STACK_DEPTH = rpn_pkg::StackDepthDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rpn_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rpn_pkg::t_out_item  o_out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int MW = $clog2(rpn_pkg::MaxResults + 1);

    logic [31:0]       r_mem [STACK_DEPTH];
    logic [31:0]       r_rd;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [31:0]       mem_wdata;

    rpn_pkg::t_state   r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [3:0]        r_cmd, n_cmd;
    logic [31:0]       r_opv, n_opv;
    logic [31:0]       r_a, n_a;
    logic [31:0]       r_b, n_b;
    logic [MW-1:0]     r_left, n_left;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic              r_swap2, n_swap2;
    logic              r_ovalid, n_ovalid;
    rpn_pkg::t_out_item r_out, n_out;

    rpn_pkg::t_alu_req alu_req;
    rpn_pkg::t_alu_rsp alu_rsp;

    logic [32:0] w_addsub;
    logic        w_as_ovf;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    rpn_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_rsp  (alu_rsp)
    );

    assign w_addsub = (r_cmd == rpn_pkg::CMD_ADD)
                    ? ({r_a[31], r_a} + {r_b[31], r_b})
                    : ({r_a[31], r_a} - {r_b[31], r_b});
    assign w_as_ovf = w_addsub[32] != w_addsub[31];

    function automatic rpn_pkg::t_out_item mk(input rpn_pkg::t_status st,
                                              input logic [31:0] v, input logic last);
        rpn_pkg::t_out_item o;
        o.status       = st;
        o.result_value = (st == rpn_pkg::ST_OK) ? v : 32'd0;
        o.last_result  = last;
        return o;
    endfunction

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_cmd    = r_cmd;
        n_opv    = r_opv;
        n_a      = r_a;
        n_b      = r_b;
        n_left   = r_left;
        n_ptr    = r_ptr;
        n_swap2  = r_swap2;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        mem_we   = 1'b0;
        mem_waddr = r_cnt[AW-1:0];
        mem_wdata = r_opv;
        mem_raddr = r_ptr[AW-1:0];
        alu_req  = '0;
        o_in_stall = (r_state != rpn_pkg::S_IDLE);

        unique case (r_state)
            rpn_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_in_data.command;
                    n_opv = i_in_data.operand_value;
                    priority if (i_in_data.command == rpn_pkg::CMD_PUSH) begin
                        if (r_cnt == CW'(STACK_DEPTH)) begin
                            n_out = mk(rpn_pkg::ST_FULL, 32'd0, 1'b1);
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = i_in_data.operand_value;
                            n_cnt     = r_cnt + CW'(1);
                            n_out = mk(rpn_pkg::ST_OK, i_in_data.operand_value, 1'b1);
                        end
                        n_state = rpn_pkg::S_OUT;
                        n_ovalid = 1'b1;
                    end else if (i_in_data.command == rpn_pkg::CMD_CLEAR) begin
                        n_cnt = '0;
                        n_out = mk(rpn_pkg::ST_OK, 32'd0, 1'b1);
                        n_state = rpn_pkg::S_OUT;
                        n_ovalid = 1'b1;
                    end else if (i_in_data.command == rpn_pkg::CMD_DUP ||
                                 i_in_data.command == rpn_pkg::CMD_TOP ||
                                 i_in_data.command == rpn_pkg::CMD_ALL) begin
                        if (r_cnt == '0) begin
                            n_out = mk(rpn_pkg::ST_EMPTY, 32'd0, 1'b1);
                            n_state = rpn_pkg::S_OUT;
                            n_ovalid = 1'b1;
                        end else begin
                            n_ptr = r_cnt - CW'(1);
                            if (i_in_data.command == rpn_pkg::CMD_ALL &&
                                32'(r_cnt) > 32'(rpn_pkg::MaxResults)) begin
                                n_left = MW'(rpn_pkg::MaxResults);
                            end else if (i_in_data.command == rpn_pkg::CMD_ALL) begin
                                n_left = MW'(r_cnt);
                            end else begin
                                n_left = MW'(1);
                            end
                            n_state = rpn_pkg::S_SHOW_RD;
                        end
                    end else begin
                        // binary path: pop b then a
                        if (r_cnt < CW'(2)) begin
                            n_cnt = '0;
                            n_out = mk(rpn_pkg::ST_EMPTY, 32'd0, 1'b1);
                            n_state = rpn_pkg::S_OUT;
                            n_ovalid = 1'b1;
                        end else begin
                            n_ptr = r_cnt - CW'(1);
                            n_cnt = r_cnt - CW'(2);
                            n_state = rpn_pkg::S_RD_B;
                        end
                    end
                end
            end
            rpn_pkg::S_RD_B: begin
                n_ptr = r_ptr - CW'(1);
                n_state = rpn_pkg::S_RD_A;
            end
            rpn_pkg::S_RD_A: begin
                n_b = r_rd;
                n_state = rpn_pkg::S_EXEC;
            end
            rpn_pkg::S_EXEC: begin
                n_a = r_rd;
                n_state = rpn_pkg::S_OUT;
                n_ovalid = 1'b1;
                unique case (r_cmd)
                    rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB: begin
                        n_state = rpn_pkg::S_SWAP_WR;  // r_a valid next cycle
                        n_ovalid = 1'b0;
                    end
                    rpn_pkg::CMD_MUL: begin
                        alu_req = '{start: 1'b1, op: rpn_pkg::ALU_MUL, a: r_rd, b: r_b};
                        n_state = rpn_pkg::S_ALU_WAIT;
                        n_ovalid = 1'b0;
                    end
                    rpn_pkg::CMD_DIV: begin
                        if (r_b == 32'd0) begin
                            n_out = mk(rpn_pkg::ST_DIVZERO, 32'd0, 1'b1);
                        end else begin
                            alu_req = '{start: 1'b1, op: rpn_pkg::ALU_DIV, a: r_rd, b: r_b};
                            n_state = rpn_pkg::S_ALU_WAIT;
                            n_ovalid = 1'b0;
                        end
                    end
                    rpn_pkg::CMD_SWAP: begin
                        // write b at the lower slot, then a above it
                        mem_we = 1'b1;
                        mem_waddr = r_cnt[AW-1:0];
                        mem_wdata = r_b;
                        n_cnt = r_cnt + CW'(1);
                        n_swap2 = 1'b1;
                        n_state = rpn_pkg::S_SWAP_WR;
                        n_ovalid = 1'b0;
                    end
                    default: begin
                        n_out = mk(rpn_pkg::ST_INVALID, 32'd0, 1'b1);
                    end
                endcase
            end
            rpn_pkg::S_SWAP_WR: begin
                n_state = rpn_pkg::S_OUT;
                n_ovalid = 1'b1;
                n_swap2 = 1'b0;
                if (r_swap2) begin
                    mem_we = 1'b1;
                    mem_wdata = r_a;
                    n_cnt = r_cnt + CW'(1);
                    n_out = mk(rpn_pkg::ST_OK, r_a, 1'b1);
                end else if (w_as_ovf) begin
                    n_out = mk(rpn_pkg::ST_OVERFLOW, 32'd0, 1'b1);
                end else begin
                    mem_we = 1'b1;
                    mem_wdata = w_addsub[31:0];
                    n_cnt = r_cnt + CW'(1);
                    n_out = mk(rpn_pkg::ST_OK, w_addsub[31:0], 1'b1);
                end
            end
            rpn_pkg::S_ALU_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = rpn_pkg::S_OUT;
                    n_ovalid = 1'b1;
                    if (alu_rsp.ovf) begin
                        n_out = mk(rpn_pkg::ST_OVERFLOW, 32'd0, 1'b1);
                    end else begin
                        mem_we = 1'b1;
                        mem_wdata = alu_rsp.value;
                        n_cnt = r_cnt + CW'(1);
                        n_out = mk(rpn_pkg::ST_OK, alu_rsp.value, 1'b1);
                    end
                end
            end
            rpn_pkg::S_SHOW_RD: begin
                n_state = rpn_pkg::S_SHOW_OUT;
            end
            rpn_pkg::S_SHOW_OUT: begin
                n_ovalid = 1'b1;
                n_state = rpn_pkg::S_OUT;
                if (r_cmd == rpn_pkg::CMD_DUP) begin
                    if (r_cnt == CW'(STACK_DEPTH)) begin
                        n_out = mk(rpn_pkg::ST_FULL, 32'd0, 1'b1);
                    end else begin
                        mem_we = 1'b1;
                        mem_wdata = r_rd;
                        n_cnt = r_cnt + CW'(1);
                        n_out = mk(rpn_pkg::ST_OK, r_rd, 1'b1);
                    end
                end else begin
                    n_out = mk(rpn_pkg::ST_OK, r_rd, r_left == MW'(1));
                    n_left = r_left - MW'(1);
                    n_ptr = r_ptr - CW'(1);
                end
            end
            rpn_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_ovalid = 1'b0;
                    // advance to the next entry of a show-all listing
                    if (!r_out.last_result) begin
                        n_state = rpn_pkg::S_SHOW_RD;
                    end else begin
                        n_state = rpn_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = rpn_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rpn_pkg::S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_swap2  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_swap2  <= n_swap2;
        end
        r_cmd  <= n_cmd;
        r_opv  <= n_opv;
        r_a    <= n_a;
        r_b    <= n_b;
        r_left <= n_left;
        r_ptr  <= n_ptr;
        r_out  <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `RPN_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_cnt <= CW'(STACK_DEPTH), "count > depth")
    `RPN_ASSERT_IMPL(a_valid_in_out, i_clk, i_rst_n, r_ovalid, r_state == rpn_pkg::S_OUT, "stray valid")
    `RPN_ASSERT_IMPL(a_idle_no_out, i_clk, i_rst_n, r_state == rpn_pkg::S_IDLE, !o_out_valid && !o_in_stall, "idle busy")

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RPN stack calculator core. A short table of
// directed commands covers the empty, overflow, divide-by-zero and invalid
// statuses and the operand extremes. A random command stream follows, with
// push bursts that fill the stack. Each result is checked against a stack
// model kept in the bench. Both sides insert random gaps, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH       = rpn_pkg::StackDepthDef;
    localparam int RAND_ITEMS  = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [3:0] CMD_BAD_LO = 4'd10;
    localparam logic [3:0] CMD_BAD_HI = 4'd15;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

    typedef struct {
        logic [3:0]       cmd;
        logic [31:0]      val;
        bit               known;
        rpn_pkg::t_status st;
        logic [31:0]      rv;
    } t_cmd_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    rpn_pkg::t_in_item   i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    rpn_pkg::t_out_item  o_out_data;

    rpn_pkg::t_out_item  pending_results[$];
    longint     calc_stack[DEPTH];
    int         calc_depth;
    int         mismatches;
    int         cycles;
    bit         long_hold;

    rpn_stack_calculator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic rpn_pkg::t_out_item make_result(rpn_pkg::t_status st, longint v,
                                                       bit last);
        rpn_pkg::t_out_item r;
        r.status       = st;
        r.result_value = v[31:0];
        r.last_result  = last;
        return r;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Compute the results of one command and advance the stack model.
    function automatic void predict_results(rpn_pkg::t_in_item it);
        longint a, b, r;
        int n;
        rpn_pkg::t_status st;
        case (it.command)
            rpn_pkg::CMD_PUSH: begin
                if (calc_depth >= DEPTH) begin
                    pending_results.push_back(make_result(rpn_pkg::ST_FULL, 0, 1));
                end else begin
                    calc_stack[calc_depth++] = longint'(it.operand_value);
                    pending_results.push_back(
                        make_result(rpn_pkg::ST_OK, it.operand_value, 1));
                end
            end
            rpn_pkg::CMD_DUP: begin
                if (calc_depth == 0) begin
                    pending_results.push_back(make_result(rpn_pkg::ST_EMPTY, 0, 1));
                end else if (calc_depth >= DEPTH) begin
                    pending_results.push_back(make_result(rpn_pkg::ST_FULL, 0, 1));
                end else begin
                    r = calc_stack[calc_depth - 1];
                    calc_stack[calc_depth++] = r;
                    pending_results.push_back(make_result(rpn_pkg::ST_OK, r, 1));
                end
            end
            rpn_pkg::CMD_TOP, rpn_pkg::CMD_ALL: begin
                if (calc_depth == 0) begin
                    pending_results.push_back(make_result(rpn_pkg::ST_EMPTY, 0, 1));
                end else begin
                    n = (it.command == rpn_pkg::CMD_TOP) ? 1 : calc_depth;
                    if (n > rpn_pkg::MaxResults) n = rpn_pkg::MaxResults;
                    for (int i = 0; i < n; i++)
                        pending_results.push_back(
                            make_result(rpn_pkg::ST_OK, calc_stack[calc_depth - 1 - i],
                                        i + 1 == n));
                end
            end
            rpn_pkg::CMD_CLEAR: begin
                calc_depth = 0;
                pending_results.push_back(make_result(rpn_pkg::ST_OK, 0, 1));
            end
            default: begin
                // binary path; a lone operand is popped and dropped
                if (calc_depth < 2) begin
                    calc_depth = 0;
                    pending_results.push_back(make_result(rpn_pkg::ST_EMPTY, 0, 1));
                end else begin
                    b = calc_stack[--calc_depth];
                    a = calc_stack[--calc_depth];
                    st = rpn_pkg::ST_OK;
                    r = 0;
                    case (it.command)
                        rpn_pkg::CMD_ADD: r = a + b;
                        rpn_pkg::CMD_SUB: r = a - b;
                        rpn_pkg::CMD_MUL: r = a * b;
                        rpn_pkg::CMD_DIV: begin
                            if (b == 0) st = rpn_pkg::ST_DIVZERO;
                            else if (a == -64'sd2147483648 && b == -1)
                                st = rpn_pkg::ST_OVERFLOW;
                            else r = a / b;
                        end
                        rpn_pkg::CMD_SWAP: ;
                        default: st = rpn_pkg::ST_INVALID;
                    endcase
                    if (it.command == rpn_pkg::CMD_SWAP) begin
                        calc_stack[calc_depth++] = b;
                        calc_stack[calc_depth++] = a;
                        pending_results.push_back(make_result(rpn_pkg::ST_OK, a, 1));
                    end else begin
                        if (st == rpn_pkg::ST_OK &&
                            (r < -64'sd2147483648 || r > 64'sd2147483647))
                            st = rpn_pkg::ST_OVERFLOW;
                        if (st == rpn_pkg::ST_OK) calc_stack[calc_depth++] = r;
                        else r = 0;
                        pending_results.push_back(make_result(st, r, 1));
                    end
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0d] mismatch %s: got %0h want %0h", cycles, what, got, want);
        mismatches++;
    endtask

    // Offer one command, hold it until the transfer, then queue its results.
    task automatic issue(rpn_pkg::t_in_item it, bit known, rpn_pkg::t_status st,
                         logic [31:0] rv);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (known) begin
            predict_results(it);
            void'(pending_results.pop_back());
            pending_results.push_back(make_result(st, rv, 1));
        end else begin
            predict_results(it);
        end
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return INT_MIN;
            1: return INT_MAX;
            2: return 32'($signed($urandom_range(0, 2)) - 1);
            3: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return rpn_pkg::CMD_PUSH;
        if (r < 48) return rpn_pkg::CMD_ADD;
        if (r < 54) return rpn_pkg::CMD_SUB;
        if (r < 60) return rpn_pkg::CMD_MUL;
        if (r < 66) return rpn_pkg::CMD_DIV;
        if (r < 71) return rpn_pkg::CMD_SWAP;
        if (r < 76) return rpn_pkg::CMD_DUP;
        if (r < 82) return rpn_pkg::CMD_TOP;
        if (r < 87) return rpn_pkg::CMD_ALL;
        if (r < 90) return rpn_pkg::CMD_CLEAR;
        if (r < 95) return 4'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        return 4'($urandom_range(0, 15));
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_out_data.result_value, 0);
            end else begin
                rpn_pkg::t_out_item want;
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.result_value !== want.result_value)
                    report_mismatch("result_value", o_out_data.result_value,
                                    want.result_value);
                if (o_out_data.last_result !== want.last_result)
                    report_mismatch("last_result", o_out_data.last_result,
                                    want.last_result);
            end
        end
    end

    // Receiver stalls: short random ones, quiet stretches, and one long hold.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(negedge i_clk);
            if (quiet > 0) quiet--;
            else if ($urandom_range(0, 99) == 0) quiet = $urandom_range(20, 80);
            if (long_hold) i_out_stall <= 1'b1;
            else if (quiet > 0) i_out_stall <= 1'b0;
            else i_out_stall <= (gap_length() > 0);
        end
    end

    initial begin
        long_hold = 1'b0;
        wait (cycles > 1000);
        @(negedge i_clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        long_hold = 1'b0;
    end

    initial begin
        t_cmd_row rows[] = '{
            '{rpn_pkg::CMD_TOP,   0,       1, rpn_pkg::ST_EMPTY,    0},
            '{rpn_pkg::CMD_ALL,   0,       1, rpn_pkg::ST_EMPTY,    0},
            '{rpn_pkg::CMD_ADD,   0,       1, rpn_pkg::ST_EMPTY,    0},
            '{rpn_pkg::CMD_DUP,   0,       1, rpn_pkg::ST_EMPTY,    0},
            '{rpn_pkg::CMD_PUSH,  INT_MAX, 1, rpn_pkg::ST_OK,       INT_MAX},
            '{rpn_pkg::CMD_ADD,   0,       1, rpn_pkg::ST_EMPTY,    0},
            '{rpn_pkg::CMD_PUSH,  INT_MAX, 0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_PUSH,  1,       0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_ADD,   0,       1, rpn_pkg::ST_OVERFLOW, 0},
            '{rpn_pkg::CMD_PUSH,  INT_MIN, 1, rpn_pkg::ST_OK,       INT_MIN},
            '{rpn_pkg::CMD_PUSH,  '1,      0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_DIV,   0,       1, rpn_pkg::ST_OVERFLOW, 0},
            '{rpn_pkg::CMD_PUSH,  5,       0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_PUSH,  0,       0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_DIV,   0,       1, rpn_pkg::ST_DIVZERO,  0},
            '{rpn_pkg::CMD_PUSH,  INT_MIN, 0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_PUSH,  1,       0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_SUB,   0,       1, rpn_pkg::ST_OVERFLOW, 0},
            '{rpn_pkg::CMD_PUSH,  65536,   0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_PUSH,  65536,   0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_MUL,   0,       1, rpn_pkg::ST_OVERFLOW, 0},
            '{rpn_pkg::CMD_PUSH,  -7,      0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_PUSH,  2,       0, rpn_pkg::ST_OK,       0},
            '{CMD_BAD_HI,         0,       1, rpn_pkg::ST_INVALID,  0},
            '{rpn_pkg::CMD_PUSH,  -7,      0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_PUSH,  2,       0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_DIV,   0,       0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_PUSH,  9,       0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_SWAP,  0,       0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_DUP,   0,       0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_ALL,   0,       0, rpn_pkg::ST_OK,       0},
            '{rpn_pkg::CMD_CLEAR, 0,       1, rpn_pkg::ST_OK,       0}
        };
        rpn_pkg::t_in_item it;
        int burst;
        calc_depth = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            it.command       = rows[i].cmd;
            it.operand_value = rows[i].val;
            issue(it, rows[i].known, rows[i].st, rows[i].rv);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // now and then fill the stack past its depth
            burst = (n % 60 == 30) ? DEPTH + 2 : 0;
            for (int k = 0; k < burst; k++) begin
                it.command       = rpn_pkg::CMD_PUSH;
                it.operand_value = pick_value();
                issue(it, 0, rpn_pkg::ST_OK, 0);
            end
            it.command       = pick_command();
            it.operand_value = pick_value();
            issue(it, 0, rpn_pkg::ST_OK, 0);
        end
        i_in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+design
design/rpn_pkg.sv
design/rpn_alu.sv
design/rpn_stack_calculator_core.sv
bench/tb.sv
